FILE: src/rv64ie_pkg.sv
`default_nettype none

package rv64ie_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
    localparam logic [6:0] OPC_OPW    = 7'b0111011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_SRA    = 6'h10;

    localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
    localparam logic [4:0]  A0_INDEX    = 5'd10;

    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_LOAD  = 3'd1;
    localparam logic [2:0] REQ_STORE = 3'd2;
    localparam logic [2:0] REQ_CSRW  = 3'd3;
    localparam logic [2:0] REQ_CSRS  = 3'd4;

    localparam logic [1:0] TRAP_NONE    = 2'd0;
    localparam logic [1:0] TRAP_ECALL   = 2'd1;
    localparam logic [1:0] TRAP_EBREAK  = 2'd2;
    localparam logic [1:0] TRAP_ILLEGAL = 2'd3;

    localparam logic [2:0] EXT_SB   = 3'd0;
    localparam logic [2:0] EXT_SH   = 3'd1;
    localparam logic [2:0] EXT_SW   = 3'd2;
    localparam logic [2:0] EXT_FULL = 3'd3;
    localparam logic [2:0] EXT_ZB   = 3'd4;
    localparam logic [2:0] EXT_ZH   = 3'd5;
    localparam logic [2:0] EXT_ZW   = 3'd6;

    localparam logic [2:0] MD_MUL    = 3'd0;
    localparam logic [2:0] MD_MULH   = 3'd1;
    localparam logic [2:0] MD_MULHSU = 3'd2;
    localparam logic [2:0] MD_MULHU  = 3'd3;
    localparam logic [2:0] MD_DIV    = 3'd4;
    localparam logic [2:0] MD_DIVU   = 3'd5;
    localparam logic [2:0] MD_REM    = 3'd6;
    localparam logic [2:0] MD_REMU   = 3'd7;

    typedef struct packed {
        logic        func;
        logic [31:0] inst_word;
        logic [63:0] inst_pc;
        logic [63:0] return_data;
    } in_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic        dest_write;
        logic [2:0]  request_kind;
        logic [63:0] request_address;
        logic [1:0]  request_size;
        logic [63:0] request_data;
        logic        awaiting_return;
        logic [1:0]  trap_kind;
        logic [63:0] trap_value;
    } out_t;

    typedef struct packed {
        logic       md;
        logic       md_word;
        logic [2:0] md_f3;
        logic       wait_ret;
        logic [2:0] mode;
    } exec_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MD,
        ST_WB
    } state_t;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] extend_ret(input logic [63:0] v, input logic [2:0] mode);
        logic [63:0] r;
        case (mode)
            EXT_SB:  r = {{56{v[7]}}, v[7:0]};
            EXT_SH:  r = {{48{v[15]}}, v[15:0]};
            EXT_SW:  r = {{32{v[31]}}, v[31:0]};
            EXT_ZB:  r = {56'd0, v[7:0]};
            EXT_ZH:  r = {48'd0, v[15:0]};
            EXT_ZW:  r = {32'd0, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/rv64ie_regfile.sv
`default_nettype none

module rv64ie_regfile (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        rd_en,
    input  wire logic [4:0]  rd_addr1,
    input  wire logic [4:0]  rd_addr2,
    output logic      [63:0] rd_data1,
    output logic      [63:0] rd_data2,
    input  wire logic        wr_en,
    input  wire logic [4:0]  wr_addr,
    input  wire logic [63:0] wr_data
);
    import rv64ie_pkg::*;

    logic [63:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [63:0]          q1_reg, q2_reg;
    logic                 ok1_reg, ok2_reg;
    logic                 hit1, hit2, wr_ok;

    // x0, out-of-range and never-written entries read as zero
    assign hit1  = (rd_addr1 != 5'd0) && (int'(rd_addr1) < REG_COUNT)
                   && vld_reg[rd_addr1[REG_AW-1:0]];
    assign hit2  = (rd_addr2 != 5'd0) && (int'(rd_addr2) < REG_COUNT)
                   && vld_reg[rd_addr2[REG_AW-1:0]];
    assign wr_ok = wr_en && (wr_addr != 5'd0) && (int'(wr_addr) < REG_COUNT);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr[REG_AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            q1_reg <= mem[rd_addr1[REG_AW-1:0]];
            q2_reg <= mem[rd_addr2[REG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            ok1_reg <= 1'b0;
            ok2_reg <= 1'b0;
        end else begin
            if (wr_ok) begin
                vld_reg[wr_addr[REG_AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                ok1_reg <= hit1;
                ok2_reg <= hit2;
            end
        end
    end

    assign rd_data1 = ok1_reg ? q1_reg : 64'd0;
    assign rd_data2 = ok2_reg ? q2_reg : 64'd0;

endmodule

`default_nettype wire

FILE: src/rv64ie_muldiv.sv
`default_nettype none

module rv64ie_muldiv (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [2:0]  f3,
    input  wire logic        word,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic      [63:0] result
);
    import rv64ie_pkg::*;

    localparam int STEPS = 64;
    localparam int CW    = $clog2(STEPS);

    logic          busy_reg, fin_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0]   acc_reg, lo_reg, dvs_reg, opa_reg, opb_reg, res_reg;
    logic [2:0]    f3_reg;
    logic          word_reg, nq_reg, nr_reg;

    logic [63:0] opa, opb, ua, ub, post, post_w;
    logic        is_sdiv;
    logic [64:0] msum, rsh, rdiff;

    always_comb begin
        is_sdiv = f3[2] && !f3[0];
        if (word) begin
            opa = is_sdiv ? sext32(a[31:0]) : {32'd0, a[31:0]};
            opb = is_sdiv ? sext32(b[31:0]) : {32'd0, b[31:0]};
        end else begin
            opa = a;
            opb = b;
        end
        ua = (is_sdiv && opa[63]) ? (64'd0 - opa) : opa;
        ub = (is_sdiv && opb[63]) ? (64'd0 - opb) : opb;
    end

    // shift-add multiply and restoring divide, one bit per cycle
    assign msum  = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, dvs_reg} : 65'd0);
    assign rsh   = {acc_reg, lo_reg[63]};
    assign rdiff = rsh - {1'b0, dvs_reg};

    always_comb begin
        case (f3_reg)
            MD_MUL:    post = lo_reg;
            MD_MULH:   post = acc_reg - (opa_reg[63] ? opb_reg : 64'd0)
                                      - (opb_reg[63] ? opa_reg : 64'd0);
            MD_MULHSU: post = acc_reg - (opa_reg[63] ? opb_reg : 64'd0);
            MD_MULHU:  post = acc_reg;
            MD_DIV:    post = nq_reg ? (64'd0 - lo_reg) : lo_reg;
            MD_DIVU:   post = lo_reg;
            MD_REM:    post = nr_reg ? (64'd0 - acc_reg) : acc_reg;
            default:   post = acc_reg;
        endcase
        post_w = word_reg ? sext32(post[31:0]) : post;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            opa_reg  <= opa;
            opb_reg  <= opb;
            f3_reg   <= f3;
            word_reg <= word;
            acc_reg  <= 64'd0;
            lo_reg   <= f3[2] ? ua : opa;
            dvs_reg  <= f3[2] ? ub : opb;
            nq_reg   <= is_sdiv && (opa[63] ^ opb[63]) && (opb != 64'd0);
            nr_reg   <= is_sdiv && opa[63];
        end else if (busy_reg) begin
            if (f3_reg[2]) begin
                if (!rdiff[64]) begin
                    acc_reg <= rdiff[63:0];
                    lo_reg  <= {lo_reg[62:0], 1'b1};
                end else begin
                    acc_reg <= rsh[63:0];
                    lo_reg  <= {lo_reg[62:0], 1'b0};
                end
            end else begin
                acc_reg <= msum[64:1];
                lo_reg  <= {msum[0], lo_reg[63:1]};
            end
        end
        if (fin_reg) begin
            res_reg <= post_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: src/rv64ie_exec.sv
`default_nettype none

module rv64ie_exec (
    input  wire logic [31:0]          inst,
    input  wire logic [63:0]          pc,
    input  wire logic [63:0]          a,
    input  wire logic [63:0]          b,
    output rv64ie_pkg::out_t          res,
    output rv64ie_pkg::exec_ctl_t     ctl
);
    import rv64ie_pkg::*;

    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u, pc4;
    logic [63:0] sum_i, sum_r, diff_r, opb;
    logic [5:0]  shamt;
    logic [63:0] sh_l, sh_rl, sh_ra, w_sll, w_srl, w_sra;
    logic        lt_s, lt_u, taken, ill, wr, wait_ret, md, mdw;
    logic [63:0] npc, wv, raddr, rdata, tval;
    logic [1:0]  trap, size;
    logic [2:0]  kind, mode;

    always_comb begin
        op    = inst[6:0];
        f3    = inst[14:12];
        f7    = inst[31:25];
        rd    = inst[11:7];
        imm_i = {{52{inst[31]}}, inst[31:20]};
        imm_s = {{52{inst[31]}}, inst[31:25], inst[11:7]};
        imm_b = {{51{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        imm_j = {{43{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        imm_u = {{32{inst[31]}}, inst[31:12], 12'd0};
        pc4   = pc + 64'd4;
        sum_i = a + imm_i;
        sum_r = a + b;
        diff_r = a - b;
        opb   = (op == OPC_OPIMM) ? imm_i : b;
        lt_s  = $signed(a) < $signed(opb);
        lt_u  = a < opb;
        shamt = (op == OPC_OPIMM || op == OPC_OPIMMW) ? inst[25:20] : b[5:0];
        sh_l  = a << shamt;
        sh_rl = a >> shamt;
        sh_ra = $signed(a) >>> shamt;
        w_sll = sext32(a[31:0] << shamt[4:0]);
        w_srl = sext32(a[31:0] >> shamt[4:0]);
        w_sra = sext32($signed(a[31:0]) >>> shamt[4:0]);
    end

    always_comb begin
        npc      = pc4;
        wv       = 64'd0;
        wr       = 1'b0;
        ill      = 1'b0;
        trap     = TRAP_NONE;
        tval     = 64'd0;
        kind     = REQ_NONE;
        raddr    = 64'd0;
        size     = 2'd0;
        rdata    = 64'd0;
        wait_ret = 1'b0;
        mode     = EXT_FULL;
        md       = 1'b0;
        mdw      = 1'b0;
        taken    = 1'b0;
        case (op)
            OPC_LUI: begin
                wr = 1'b1;
                wv = imm_u;
            end
            OPC_AUIPC: begin
                wr = 1'b1;
                wv = pc + imm_u;
            end
            OPC_JAL: begin
                wr  = 1'b1;
                wv  = pc4;
                npc = pc + imm_j;
            end
            OPC_JALR: begin
                if (f3 != 3'd0) begin
                    ill = 1'b1;
                end else begin
                    wr  = 1'b1;
                    wv  = pc4;
                    npc = {sum_i[63:1], 1'b0};
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0:    taken = (a == b);
                    3'd1:    taken = (a != b);
                    3'd4:    taken = lt_s;
                    3'd5:    taken = !lt_s;
                    3'd6:    taken = lt_u;
                    3'd7:    taken = !lt_u;
                    default: ill = 1'b1;
                endcase
                if (taken) begin
                    npc = pc + imm_b;
                end
            end
            OPC_LOAD: begin
                if (f3 == 3'd7) begin
                    ill = 1'b1;
                end else begin
                    kind     = REQ_LOAD;
                    raddr    = sum_i;
                    size     = f3[1:0];
                    wait_ret = 1'b1;
                    mode     = f3;
                end
            end
            OPC_STORE: begin
                if (f3[2]) begin
                    ill = 1'b1;
                end else begin
                    kind  = REQ_STORE;
                    raddr = a + imm_s;
                    size  = f3[1:0];
                    rdata = b;
                end
            end
            OPC_OPIMM: begin
                wr = 1'b1;
                case (f3)
                    3'd0: wv = sum_i;
                    3'd2: wv = {63'd0, lt_s};
                    3'd3: wv = {63'd0, lt_u};
                    3'd4: wv = a ^ imm_i;
                    3'd6: wv = a | imm_i;
                    3'd7: wv = a & imm_i;
                    3'd1: begin
                        if (inst[31:26] == 6'd0) wv = sh_l;
                        else ill = 1'b1;
                    end
                    default: begin
                        if (inst[31:26] == 6'd0) wv = sh_rl;
                        else if (inst[31:26] == F6_SRA) wv = sh_ra;
                        else ill = 1'b1;
                    end
                endcase
            end
            OPC_OP: begin
                wr = 1'b1;
                if (f7 == F7_MULDIV) begin
                    md = 1'b1;
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0:    wv = sum_r;
                        3'd1:    wv = sh_l;
                        3'd2:    wv = {63'd0, lt_s};
                        3'd3:    wv = {63'd0, lt_u};
                        3'd4:    wv = a ^ b;
                        3'd5:    wv = sh_rl;
                        3'd6:    wv = a | b;
                        default: wv = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    wv = diff_r;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    wv = sh_ra;
                end else begin
                    ill = 1'b1;
                end
            end
            OPC_OPIMMW: begin
                wr = 1'b1;
                if (f3 == 3'd0) wv = sext32(sum_i[31:0]);
                else if (f3 == 3'd1 && f7 == F7_BASE) wv = w_sll;
                else if (f3 == 3'd5 && f7 == F7_BASE) wv = w_srl;
                else if (f3 == 3'd5 && f7 == F7_ALT) wv = w_sra;
                else ill = 1'b1;
            end
            OPC_OPW: begin
                wr = 1'b1;
                if (f7 == F7_BASE && f3 == 3'd0) wv = sext32(sum_r[31:0]);
                else if (f7 == F7_BASE && f3 == 3'd1) wv = w_sll;
                else if (f7 == F7_BASE && f3 == 3'd5) wv = w_srl;
                else if (f7 == F7_ALT && f3 == 3'd0) wv = sext32(diff_r[31:0]);
                else if (f7 == F7_ALT && f3 == 3'd5) wv = w_sra;
                else if (f7 == F7_MULDIV && (f3 == MD_MUL || f3[2])) begin
                    md  = 1'b1;
                    mdw = 1'b1;
                end else ill = 1'b1;
            end
            OPC_SYSTEM: begin
                if (inst == INST_ECALL) begin
                    trap = TRAP_ECALL;
                    tval = pc;
                end else if (inst == INST_EBREAK) begin
                    // rs1 port was pointed at a0 for this one
                    trap = TRAP_EBREAK;
                    tval = a;
                end else if (f3 == 3'd1) begin
                    kind     = REQ_CSRW;
                    raddr    = {52'd0, inst[31:20]};
                    rdata    = a;
                    wait_ret = (rd != 5'd0);
                end else if (f3 == 3'd2) begin
                    kind     = REQ_CSRS;
                    raddr    = {52'd0, inst[31:20]};
                    rdata    = a;
                    wait_ret = 1'b1;
                end else begin
                    ill = 1'b1;
                end
            end
            default: ill = 1'b1;
        endcase
    end

    always_comb begin
        res = '0;
        ctl = '0;
        if (ill) begin
            res.trap_kind  = TRAP_ILLEGAL;
            res.trap_value = pc;
        end else if (trap != TRAP_NONE) begin
            res.trap_kind  = trap;
            res.trap_value = tval;
        end else begin
            res.next_pc = npc;
            if (wr && rd != 5'd0 && int'(rd) < REG_COUNT) begin
                res.dest_index = rd;
                res.dest_value = wv;
                res.dest_write = 1'b1;
            end
            res.request_kind    = kind;
            res.request_address = raddr;
            res.request_size    = size;
            res.request_data    = rdata;
            res.awaiting_return = wait_ret;
            ctl.md       = md;
            ctl.md_word  = mdw;
            ctl.md_f3    = f3;
            ctl.wait_ret = wait_ret;
            ctl.mode     = mode;
        end
    end

endmodule

`default_nettype wire

FILE: src/rv64im_execute_unit.sv
// Flow: an accepted transaction is registered with its register file read, then executed
//   and written to the output register; multiply, divide and remainder wait in between
//   for the bit-serial multiply/divide unit. A new transaction is taken only once the
//   last one is written back, and write-back waits for the output register to be free.
//   A finished result waits in the output register while the next transaction is taken.
// Reset: register file valid bits and pending return are cleared at once; no sweep.
`default_nettype none

module rv64im_execute_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rv64ie_pkg::in_t   s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rv64ie_pkg::out_t       m_data
);
    import rv64ie_pkg::*;

    state_t    state_reg, state_next;
    in_t       in_reg;
    out_t      m_data_reg, ex_out, ret_out, wb_data;
    exec_ctl_t ex_ctl;
    logic      m_valid_reg;
    logic      pend_valid_reg;
    logic [4:0] pend_dest_reg;
    logic [2:0] pend_mode_reg;

    logic        rf_rd_en, rf_we, md_start, md_done, wb_fire, out_free;
    logic [4:0]  rs1_addr;
    logic [63:0] rs1_data, rs2_data, md_result;

    assign rf_rd_en = s_valid && s_ready;
    assign rs1_addr = (s_data.inst_word == INST_EBREAK) ? A0_INDEX : s_data.inst_word[19:15];
    assign rf_we    = wb_fire && wb_data.dest_write;

    // reads only at accept, writes only at write-back: the two never overlap
    rv64ie_regfile u_rf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rf_rd_en),
        .rd_addr1 (rs1_addr),
        .rd_addr2 (s_data.inst_word[24:20]),
        .rd_data1 (rs1_data),
        .rd_data2 (rs2_data),
        .wr_en    (rf_we),
        .wr_addr  (wb_data.dest_index),
        .wr_data  (wb_data.dest_value)
    );

    rv64ie_exec u_exec (
        .inst (in_reg.inst_word),
        .pc   (in_reg.inst_pc),
        .a    (rs1_data),
        .b    (rs2_data),
        .res  (ex_out),
        .ctl  (ex_ctl)
    );

    rv64ie_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .f3      (ex_ctl.md_f3),
        .word    (ex_ctl.md_word),
        .a       (rs1_data),
        .b       (rs2_data),
        .done    (md_done),
        .result  (md_result)
    );

    always_comb begin
        ret_out = '0;
        if (pend_valid_reg && pend_dest_reg != 5'd0 && int'(pend_dest_reg) < REG_COUNT) begin
            ret_out.dest_index = pend_dest_reg;
            ret_out.dest_value = extend_ret(in_reg.return_data, pend_mode_reg);
            ret_out.dest_write = 1'b1;
        end
        if (in_reg.func) begin
            wb_data = ret_out;
        end else begin
            wb_data = ex_out;
            if (state_reg == ST_WB && ex_out.dest_write) begin
                wb_data.dest_value = md_result;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        md_start = (state_reg == ST_EXEC) && !in_reg.func && ex_ctl.md;
        wb_fire  = out_free && (((state_reg == ST_EXEC) && !md_start) || (state_reg == ST_WB));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (md_start) state_next = ST_MD;
                else if (wb_fire) state_next = ST_IDLE;
            end
            ST_MD: begin
                if (md_done) state_next = ST_WB;
            end
            ST_WB: begin
                if (wb_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rf_rd_en) begin
            in_reg <= s_data;
        end
        if (wb_fire) begin
            m_data_reg <= wb_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_dest_reg  <= 5'd0;
            pend_mode_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (wb_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wb_fire) begin
                if (in_reg.func) begin
                    pend_valid_reg <= 1'b0;
                end else if (ex_ctl.wait_ret) begin
                    pend_valid_reg <= 1'b1;
                    pend_dest_reg  <= in_reg.inst_word[11:7];
                    pend_mode_reg  <= ex_ctl.mode;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not move to execute");

    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> (wb_data.dest_index != 5'd0))
        else $error("write-back targets x0");

    a_md_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> (state_reg == ST_MD))
        else $error("multiply/divide finished outside its wait state");

    a_trap_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.trap_kind != TRAP_NONE) |-> !m_data.dest_write)
        else $error("trap result writes a register");

endmodule

`default_nettype wire
